[rtl/core/lgts_pkg.sv]
// Shared types and constants for the LDA Gibbs topic sampler.
// No dependencies; imported by every module of the block.
package lgts_pkg;

    // Fixed field and store widths
    localparam int unsigned CNT_W  = 16;   // doc-topic and topic-word counts
    localparam int unsigned TOT_W  = 24;   // per-topic totals
    localparam int unsigned WGT_W  = 40;   // weights and cumulative sums
    localparam int unsigned PRI_W  = 16;   // Q8.8 priors
    localparam int unsigned FAC_W  = 25;   // prior + count<<8
    localparam int unsigned NUM_W  = 58;   // (a*l)<<8
    localparam int unsigned DEN_W  = 34;   // V*lambda + total<<8
    localparam int unsigned VL_W   = 33;   // V*lambda
    localparam int unsigned CFG_IW = 2;
    localparam int unsigned CFG_DW = 16;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [TOT_W-1:0] TOT_MAX = '1;
    localparam logic [WGT_W-1:0] WGT_MAX = '1;
    localparam logic [PRI_W-1:0] PRI_ONE = 16'd256;

    // Configuration register indexes
    localparam logic [CFG_IW-1:0] CFG_ALPHA  = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_LAMBDA = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_TOPICS = 2'd2;
    localparam logic [CFG_IW-1:0] CFG_VOCAB  = 2'd3;

    // Opcodes
    localparam logic OP_ADD      = 1'b0;
    localparam logic OP_RESAMPLE = 1'b1;

    // Divider request and response
    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [WGT_W-1:0] quo;
    } t_div_rsp;

    // Count store commands
    typedef struct packed {
        logic rd;
        logic wr;
        logic clr;
    } t_cnt_cmd;

endpackage

[rtl/core/lgts_if.sv]
// Request and response channel interfaces of the topic sampler.
// Depends on nothing; fixed field widths.
interface lgts_req_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [9:0]  doc_index;
    logic [11:0] word_index;
    logic [5:0]  topic_in;
    logic [15:0] random_fraction;

    modport source(output valid, opcode, doc_index, word_index, topic_in,
                   random_fraction, input ready);
    modport sink(input valid, opcode, doc_index, word_index, topic_in,
                 random_fraction, output ready);
endinterface

interface lgts_rsp_if;
    logic       valid;
    logic       ready;
    logic [5:0] new_topic;
    logic       count_error;

    modport source(output valid, new_topic, count_error, input ready);
    modport sink(input valid, new_topic, count_error, output ready);
endinterface

[rtl/core/lda_gibbs_topic_sampler_unit.sv]
// LDA collapsed Gibbs topic sampler: one request in, one response out.
// Request channel i_req carries opcode, doc_index, word_index, topic_in and
// random_fraction; response channel o_rsp returns new_topic and count_error.
// Opcode 0 adds the token under topic_in; opcode 1 removes it from topic_in,
// draws a new topic from the weighted distribution and adds it back.
// Registers (alpha, lambda, topic count, vocabulary size) are written through i_cfg_we /
// i_cfg_idx / i_cfg_wdata only while no request is in flight: a user rule, not enforced.
// After reset a zeroing sweep runs over the count stores, one entry per cycle,
// through max(MAX_DOCS*MAX_TOPICS, MAX_TOPICS*MAX_VOCAB) addresses (262144 by default);
// no request is taken during the sweep.
// An add wraps the indexes, reads the counts and writes them back incremented; a
// resample first removes the old topic, then for each active topic reads the counts,
// forms the factors and their product and divides on the shared one-bit-per-cycle
// divider (40 steps); the draw then scans the cumulative weights one topic at a time.
// One request is processed at a time; ready rises in the same cycle as the
// response is registered. A finished response waits in an output register;
// the next request is accepted meanwhile and holds at its end until the
// receiver takes the previous response. Depends on lgts_pkg, lgts_if, lgts_div, lgts_counts.
module lda_gibbs_topic_sampler_unit #(
    parameter int unsigned MAX_TOPICS = 64,
    parameter int unsigned MAX_DOCS   = 1024,
    parameter int unsigned MAX_VOCAB  = 4096
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    lgts_req_if.sink                    i_req,
    lgts_rsp_if.source                  o_rsp,
    input  logic                        i_cfg_we,
    input  logic [lgts_pkg::CFG_IW-1:0] i_cfg_idx,
    input  logic [lgts_pkg::CFG_DW-1:0] i_cfg_wdata
);
    import lgts_pkg::*;

    localparam int unsigned TW    = $clog2(MAX_TOPICS);
    localparam int unsigned DTD   = MAX_DOCS * MAX_TOPICS;
    localparam int unsigned TWD   = MAX_TOPICS * MAX_VOCAB;
    localparam int unsigned DTA_W = $clog2(DTD);
    localparam int unsigned TWA_W = $clog2(TWD);
    localparam int unsigned CLR_N = (DTD > TWD) ? DTD : TWD;
    localparam int unsigned CLR_W = $clog2(CLR_N);

    // Sequencer states
    localparam logic [4:0] S_CLR   = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_WRAP  = 5'd2;
    localparam logic [4:0] S_RMRD  = 5'd3;
    localparam logic [4:0] S_RMWR  = 5'd4;
    localparam logic [4:0] S_TRD   = 5'd5;
    localparam logic [4:0] S_TMUL  = 5'd6;
    localparam logic [4:0] S_TPROD = 5'd7;
    localparam logic [4:0] S_TDIV  = 5'd8;
    localparam logic [4:0] S_TWAIT = 5'd9;
    localparam logic [4:0] S_TGT   = 5'd10;
    localparam logic [4:0] S_SRD   = 5'd11;
    localparam logic [4:0] S_SCMP  = 5'd12;
    localparam logic [4:0] S_ARD   = 5'd13;
    localparam logic [4:0] S_AWR   = 5'd14;
    localparam logic [4:0] S_DONE  = 5'd15;

    logic [4:0]        r_state, n_state;
    logic [CLR_W-1:0]  r_clr, n_clr;

    // Configuration
    logic [PRI_W-1:0]  r_alpha, r_lambda;
    logic [6:0]        r_ntop;
    logic [12:0]       r_vocab;

    // Request fields and working registers
    logic              r_op, n_op;
    logic [9:0]        r_doc, n_doc;
    logic [11:0]       r_word, n_word;
    logic [TW-1:0]     r_topic, n_topic;
    logic [15:0]       r_frac, n_frac;
    logic              r_err, n_err;
    logic [TW-1:0]     r_ti, n_ti;
    logic [WGT_W-1:0]  r_acc, n_acc;
    logic [VL_W-1:0]   r_vl, n_vl;
    logic [FAC_W-1:0]  r_a, n_a;
    logic [FAC_W-1:0]  r_l, n_l;
    logic [DEN_W-1:0]  r_den, n_den;
    logic [NUM_W-1:0]  r_num, n_num;
    logic [WGT_W-1:0]  r_target, n_target;
    logic              r_out_valid, n_out_valid;
    logic [5:0]        r_out_topic, n_out_topic;
    logic              r_out_err, n_out_err;

    // Cumulative weight memory
    logic [WGT_W-1:0]  cw_mem [MAX_TOPICS];
    logic [WGT_W-1:0]  r_cw_q;
    logic              cw_we, cw_re;

    // Count store wiring
    t_cnt_cmd          cnt_cmd;
    logic [TW-1:0]     cnt_topic;
    logic [31:0]       dt_full, tw_full;
    logic [CNT_W-1:0]  dt_q, tw_q, dt_wd, tw_wd;
    logic [TOT_W-1:0]  tot_q, tot_wd;

    t_div_req          div_req;
    t_div_rsp          div_rsp;

    // Active topic count and vocabulary size
    logic [31:0]       nt32, v32, tin32;
    logic [TW-1:0]     nt_m1;
    logic [WGT_W:0]    acc_sum;
    logic [WGT_W+15:0] tgt_prod;

    always_comb begin
        nt32 = (r_ntop == 7'd0) ? 32'd1 :
               (32'(r_ntop) > MAX_TOPICS) ? 32'(MAX_TOPICS) : 32'(r_ntop);
        v32  = (r_vocab == 13'd0) ? 32'd1 :
               (32'(r_vocab) > MAX_VOCAB) ? 32'(MAX_VOCAB) : 32'(r_vocab);
        nt_m1 = TW'(nt32 - 32'd1);
        tin32 = 32'(i_req.topic_in);
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha  <= PRI_ONE;
            r_lambda <= PRI_ONE;
            r_ntop   <= 7'd8;
            r_vocab  <= 13'd4096;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ALPHA:  r_alpha  <= (i_cfg_wdata == '0) ? PRI_ONE : i_cfg_wdata;
                CFG_LAMBDA: r_lambda <= (i_cfg_wdata == '0) ? PRI_ONE : i_cfg_wdata;
                CFG_TOPICS: r_ntop   <= i_cfg_wdata[6:0];
                CFG_VOCAB:  r_vocab  <= i_cfg_wdata[12:0];
                default: ;
            endcase
        end
    end

    // Count store addressing: the weight scan walks r_ti, else the token topic
    assign cnt_topic = (r_state == S_TRD) ? r_ti : r_topic;
    assign dt_full   = 32'(r_doc) * 32'(MAX_TOPICS) + 32'(cnt_topic);
    assign tw_full   = 32'(cnt_topic) * 32'(MAX_VOCAB) + 32'(r_word);

    assign acc_sum  = {1'b0, r_acc} + {1'b0, div_rsp.quo};
    assign tgt_prod = 56'(r_frac) * 56'(r_acc);

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_op        = r_op;
        n_doc       = r_doc;
        n_word      = r_word;
        n_topic     = r_topic;
        n_frac      = r_frac;
        n_err       = r_err;
        n_ti        = r_ti;
        n_acc       = r_acc;
        n_vl        = r_vl;
        n_a         = r_a;
        n_l         = r_l;
        n_den       = r_den;
        n_num       = r_num;
        n_target    = r_target;
        n_out_valid = r_out_valid;
        n_out_topic = r_out_topic;
        n_out_err   = r_out_err;
        cnt_cmd     = '0;
        dt_wd       = dt_q;
        tw_wd       = tw_q;
        tot_wd      = tot_q;
        cw_we       = 1'b0;
        cw_re       = 1'b0;
        div_req     = '{start: 1'b0, num: r_num, den: r_den};

        if (r_out_valid && o_rsp.ready) n_out_valid = 1'b0;

        unique case (r_state)
            S_CLR: begin
                cnt_cmd.clr = 1'b1;
                n_clr = r_clr + 1'b1;
                if (32'(r_clr) == CLR_N - 1) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_op    = i_req.opcode;
                    n_doc   = i_req.doc_index;
                    n_word  = i_req.word_index;
                    n_topic = (tin32 >= nt32) ? nt_m1 : TW'(i_req.topic_in);
                    n_frac  = i_req.random_fraction;
                    n_err   = 1'b0;
                    n_state = S_WRAP;
                end
            end
            S_WRAP: begin
                // index wrap by repeated subtraction
                if (32'(r_doc) >= MAX_DOCS) begin
                    n_doc = 10'(32'(r_doc) - MAX_DOCS);
                end else if (32'(r_word) >= MAX_VOCAB) begin
                    n_word = 12'(32'(r_word) - MAX_VOCAB);
                end else begin
                    n_vl    = VL_W'(v32) * VL_W'(r_lambda);
                    n_state = (r_op == OP_RESAMPLE) ? S_RMRD : S_ARD;
                end
            end
            S_RMRD: begin
                cnt_cmd.rd = 1'b1;
                n_state = S_RMWR;
            end
            S_RMWR: begin
                // remove old topic, saturating at zero
                cnt_cmd.wr = 1'b1;
                dt_wd  = (dt_q == '0) ? dt_q : dt_q - 1'b1;
                tw_wd  = (tw_q == '0) ? tw_q : tw_q - 1'b1;
                tot_wd = (tot_q == '0) ? tot_q : tot_q - 1'b1;
                n_err  = (dt_q == '0) || (tw_q == '0) || (tot_q == '0);
                n_ti   = '0;
                n_acc  = '0;
                n_state = S_TRD;
            end
            S_TRD: begin
                cnt_cmd.rd = 1'b1;
                n_state = S_TMUL;
            end
            S_TMUL: begin
                n_a   = FAC_W'(r_alpha) + {1'b0, dt_q, 8'd0};
                n_l   = FAC_W'(r_lambda) + {1'b0, tw_q, 8'd0};
                n_den = DEN_W'(r_vl) + DEN_W'({tot_q, 8'd0});
                n_state = S_TPROD;
            end
            S_TPROD: begin
                n_num   = {(2 * FAC_W)'(r_a) * (2 * FAC_W)'(r_l), 8'd0};
                n_state = S_TDIV;
            end
            S_TDIV: begin
                div_req.start = 1'b1;
                n_state = S_TWAIT;
            end
            S_TWAIT: begin
                if (div_rsp.done) begin
                    n_acc = acc_sum[WGT_W] ? WGT_MAX : acc_sum[WGT_W-1:0];
                    cw_we = 1'b1;
                    if (r_ti == nt_m1) begin
                        n_state = S_TGT;
                    end else begin
                        n_ti    = r_ti + 1'b1;
                        n_state = S_TRD;
                    end
                end
            end
            S_TGT: begin
                n_target = tgt_prod[WGT_W+15:16];
                n_ti     = '0;
                n_state  = S_SRD;
            end
            S_SRD: begin
                cw_re   = 1'b1;
                n_state = S_SCMP;
            end
            S_SCMP: begin
                if (r_target < r_cw_q || r_ti == nt_m1) begin
                    n_topic = r_ti;
                    n_state = S_ARD;
                end else begin
                    n_ti    = r_ti + 1'b1;
                    n_state = S_SRD;
                end
            end
            S_ARD: begin
                cnt_cmd.rd = 1'b1;
                n_state = S_AWR;
            end
            S_AWR: begin
                // add token, saturating at the maximum
                cnt_cmd.wr = 1'b1;
                dt_wd  = (dt_q == CNT_MAX) ? dt_q : dt_q + 1'b1;
                tw_wd  = (tw_q == CNT_MAX) ? tw_q : tw_q + 1'b1;
                tot_wd = (tot_q == TOT_MAX) ? tot_q : tot_q + 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out_topic = 6'(r_topic);
                    n_out_err   = r_err;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
        r_op        <= n_op;
        r_doc       <= n_doc;
        r_word      <= n_word;
        r_topic     <= n_topic;
        r_frac      <= n_frac;
        r_err       <= n_err;
        r_ti        <= n_ti;
        r_acc       <= n_acc;
        r_vl        <= n_vl;
        r_a         <= n_a;
        r_l         <= n_l;
        r_den       <= n_den;
        r_num       <= n_num;
        r_target    <= n_target;
        r_out_topic <= n_out_topic;
        r_out_err   <= n_out_err;
    end

    // Cumulative weight memory
    always_ff @(posedge i_clk) begin
        if (cw_we) cw_mem[r_ti] <= n_acc;
        if (cw_re) r_cw_q <= cw_mem[r_ti];
    end

    lgts_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    lgts_counts #(
        .TW    (TW),
        .DTA_W (DTA_W),
        .TWA_W (TWA_W),
        .DTD   (DTD),
        .TWD   (TWD),
        .NTOP  (MAX_TOPICS),
        .CLR_W (CLR_W)
    ) u_counts (
        .i_clk      (i_clk),
        .i_cmd      (cnt_cmd),
        .i_dt_addr  (dt_full[DTA_W-1:0]),
        .i_tw_addr  (tw_full[TWA_W-1:0]),
        .i_topic    (cnt_topic),
        .i_clr_addr (r_clr),
        .i_dt_wd    (dt_wd),
        .i_tw_wd    (tw_wd),
        .i_tot_wd   (tot_wd),
        .o_dt       (dt_q),
        .o_tw       (tw_q),
        .o_tot      (tot_q)
    );

    // Channel outputs
    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.new_topic   = r_out_topic;
    assign o_rsp.count_error = r_out_err;

endmodule

[rtl/core/lgts_div.sv]
// Shared restoring divider, one quotient bit per cycle, saturating at 2^40-1.
// Depends on lgts_pkg.
module lgts_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lgts_pkg::t_div_req i_req,
    output lgts_pkg::t_div_rsp o_rsp
);
    import lgts_pkg::*;

    localparam int unsigned STEP_W = $clog2(WGT_W + 1);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [STEP_W-1:0] r_step, n_step;
    logic [DEN_W-1:0]  r_rem, n_rem;
    logic [DEN_W-1:0]  r_den, n_den;
    logic [WGT_W-1:0]  r_lo, n_lo;
    logic [DEN_W:0]    trial;
    logic              fits;

    // One restoring step
    assign trial = {r_rem, r_lo[WGT_W-1]};
    assign fits  = trial >= {1'b0, r_den};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_step = r_step;
        n_rem  = r_rem;
        n_den  = r_den;
        n_lo   = r_lo;
        if (i_req.start) begin
            n_den = i_req.den;
            // quotient of 2^40 or more saturates
            if (58'(i_req.num[NUM_W-1:WGT_W]) >= 58'(i_req.den)) begin
                n_lo   = WGT_MAX;
                n_done = 1'b1;
                n_busy = 1'b0;
            end else begin
                n_rem  = DEN_W'(i_req.num[NUM_W-1:WGT_W]);
                n_lo   = i_req.num[WGT_W-1:0];
                n_step = '0;
                n_busy = 1'b1;
            end
        end else if (r_busy) begin
            n_rem = fits ? DEN_W'(trial - {1'b0, r_den}) : DEN_W'(trial);
            n_lo  = {r_lo[WGT_W-2:0], fits};
            n_step = r_step + 1'b1;
            if (r_step == STEP_W'(WGT_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_step <= n_step;
        r_rem  <= n_rem;
        r_den  <= n_den;
        r_lo   <= n_lo;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_lo;

endmodule

[rtl/core/lgts_counts.sv]
// Count stores: doc-by-topic, topic-by-word and per-topic totals.
// Registered reads, one write port each, zeroing sweep driven from outside.
module lgts_counts #(
    parameter int unsigned TW    = 6,
    parameter int unsigned DTA_W = 16,
    parameter int unsigned TWA_W = 18,
    parameter int unsigned DTD   = 65536,
    parameter int unsigned TWD   = 262144,
    parameter int unsigned NTOP  = 64,
    parameter int unsigned CLR_W = 18
) (
    input  logic                       i_clk,
    input  lgts_pkg::t_cnt_cmd         i_cmd,
    input  logic [DTA_W-1:0]           i_dt_addr,
    input  logic [TWA_W-1:0]           i_tw_addr,
    input  logic [TW-1:0]              i_topic,
    input  logic [CLR_W-1:0]           i_clr_addr,
    input  logic [lgts_pkg::CNT_W-1:0] i_dt_wd,
    input  logic [lgts_pkg::CNT_W-1:0] i_tw_wd,
    input  logic [lgts_pkg::TOT_W-1:0] i_tot_wd,
    output logic [lgts_pkg::CNT_W-1:0] o_dt,
    output logic [lgts_pkg::CNT_W-1:0] o_tw,
    output logic [lgts_pkg::TOT_W-1:0] o_tot
);
    import lgts_pkg::*;

    logic [CNT_W-1:0] dt_mem [DTD];
    logic [CNT_W-1:0] tw_mem [TWD];
    logic [TOT_W-1:0] tot_mem [NTOP];

    // Doc-topic store
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            if (32'(i_clr_addr) < DTD) dt_mem[i_clr_addr[DTA_W-1:0]] <= '0;
        end else if (i_cmd.wr) begin
            dt_mem[i_dt_addr] <= i_dt_wd;
        end
        if (i_cmd.rd) o_dt <= dt_mem[i_dt_addr];
    end

    // Topic-word store
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            if (32'(i_clr_addr) < TWD) tw_mem[i_clr_addr[TWA_W-1:0]] <= '0;
        end else if (i_cmd.wr) begin
            tw_mem[i_tw_addr] <= i_tw_wd;
        end
        if (i_cmd.rd) o_tw <= tw_mem[i_tw_addr];
    end

    // Topic totals
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            if (32'(i_clr_addr) < NTOP) tot_mem[i_clr_addr[TW-1:0]] <= '0;
        end else if (i_cmd.wr) begin
            tot_mem[i_topic] <= i_tot_wd;
        end
        if (i_cmd.rd) o_tot <= tot_mem[i_topic];
    end

endmodule
